### rtl/csv_tok_pkg.sv
// shared widths, byte codes, register indexes and row class codes for the csv tokenizer
// no dependencies; compiled first
`timescale 1ns / 1ps

package csv_tok_pkg;

  localparam int ByteW    = 8;
  localparam int ClassW   = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [ByteW-1:0] QuoteByte   = 8'd34;
  localparam logic [ByteW-1:0] NewlineByte = 8'd10;
  localparam logic [ByteW-1:0] DefaultSep  = 8'd44;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxHasDesc = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxSep     = 2'd1;

  // row class codes
  localparam logic [ClassW-1:0] ClassHeader = 2'd0;
  localparam logic [ClassW-1:0] ClassDesc   = 2'd1;
  localparam logic [ClassW-1:0] ClassData   = 2'd2;

endpackage

### rtl/csv_tok_in_if.sv
// input byte channel: valid/ready handshake with one text byte
// depends on csv_tok_pkg
`timescale 1ns / 1ps

interface csv_tok_in_if;
  logic                          valid;
  logic                          ready;
  logic [csv_tok_pkg::ByteW-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

### rtl/csv_tok_out_if.sv
// result channel: valid/ready handshake with one token result
// depends on csv_tok_pkg
`timescale 1ns / 1ps

interface csv_tok_out_if;
  logic                           valid;
  logic                           ready;
  logic                           byte_valid;
  logic [csv_tok_pkg::ByteW-1:0]  out_byte;
  logic                           field_end;
  logic                           record_end;
  logic [csv_tok_pkg::ClassW-1:0] row_class;

  modport source (output valid, output byte_valid, output out_byte, output field_end,
                  output record_end, output row_class, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input field_end,
                  input record_end, input row_class, output ready);
endinterface

### rtl/csv_record_field_tokenizer_unit.sv
// csv record/field tokenizer: input register, per-byte state update, result register
// depends on csv_tok_pkg, csv_tok_in_if, csv_tok_out_if
`timescale 1ns / 1ps

// Takes CSV text one byte per transfer and returns unescaped field bytes with
// field-end and record-end marks, each tagged header, description or data row.
// A newline closes a record only at even quote parity on the line; a field that
// opens with a quote keeps separators and folds a doubled quote into one quote.
// An empty line yields a record end with no field end; an unterminated last line
// is never closed. Throughput is one byte per clock sustained: a byte is accepted
// every cycle while the result register drains, and a byte's result (if any) moves
// from the input register to the result register once that is empty or emptying.
// Per-line state (phase, quote parity, line count) updates as each byte leaves the
// input register. Opening quotes and the first quote of a pair produce no result.
// The user writes configuration via cfg_we/cfg_index/cfg_wdata only while the block
// is idle, which the block itself does not enforce; unknown indexes are ignored.

module csv_record_field_tokenizer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  csv_tok_in_if.sink                         in_ch,
  csv_tok_out_if.source                      out_ch,
  input  logic                               cfg_we,
  input  logic [csv_tok_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [csv_tok_pkg::CfgDataW-1:0]   cfg_wdata
);

  // field phase codes
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_PLAIN  = 3'd1;
  localparam logic [2:0] PH_QUOTED = 3'd2;
  localparam logic [2:0] PH_QSEEN  = 3'd3;
  localparam logic [2:0] PH_AFTER  = 3'd4;

  // configuration registers
  logic                          has_desc_r;
  logic [csv_tok_pkg::ByteW-1:0] sep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_desc_r <= 1'b0;
      sep_r      <= csv_tok_pkg::DefaultSep;
    end else if (cfg_we) begin
      case (cfg_index)
        csv_tok_pkg::CfgIdxHasDesc: has_desc_r <= cfg_wdata[0];
        csv_tok_pkg::CfgIdxSep:     sep_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic                          in_v_r;
  logic [csv_tok_pkg::ByteW-1:0] in_byte_r;
  logic                          out_v_r;
  logic                          advance;

  // the held byte moves on when the result register is empty or being emptied
  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.text_byte;
    end
  end

  // per-line tokenizer state
  logic [1:0] line_idx_r, line_idx_nxt;
  logic       parity_r,   parity_nxt;
  logic [2:0] phase_r,    phase_nxt;
  logic       content_r,  content_nxt;

  // result computed for the held byte
  logic                           emit;
  logic                           res_bv;
  logic [csv_tok_pkg::ByteW-1:0]  res_byte;
  logic                           res_fe;
  logic                           res_re;
  logic [csv_tok_pkg::ClassW-1:0] res_class;

  logic is_quote, is_nl, is_sep;

  assign is_quote = (in_byte_r == csv_tok_pkg::QuoteByte);
  assign is_nl    = (in_byte_r == csv_tok_pkg::NewlineByte);
  assign is_sep   = (in_byte_r == sep_r);

  // row class follows the line count before this byte
  always_comb begin
    if (line_idx_r == 2'd0) begin
      res_class = csv_tok_pkg::ClassHeader;
    end else if (line_idx_r == 2'd1 && has_desc_r) begin
      res_class = csv_tok_pkg::ClassDesc;
    end else begin
      res_class = csv_tok_pkg::ClassData;
    end
  end

  always_comb begin
    parity_nxt   = parity_r ^ is_quote;
    line_idx_nxt = line_idx_r;
    phase_nxt    = phase_r;
    content_nxt  = 1'b1;
    emit         = 1'b1;
    res_bv       = 1'b0;
    res_byte     = '0;
    res_fe       = 1'b0;
    res_re       = 1'b0;

    if (is_nl && !parity_nxt) begin
      // record end; last field closes only if the line had any byte
      res_fe      = content_r;
      res_re      = 1'b1;
      phase_nxt   = PH_START;
      content_nxt = 1'b0;
      if (line_idx_r != 2'd2) begin
        line_idx_nxt = line_idx_r + 2'd1;
      end
    end else begin
      case (phase_r)
        PH_PLAIN, PH_AFTER: begin
          if (is_sep) begin
            phase_nxt = PH_START;
            res_fe    = 1'b1;
          end else begin
            res_bv   = 1'b1;
            res_byte = in_byte_r;
          end
        end
        PH_QUOTED: begin
          if (is_quote) begin
            phase_nxt = PH_QSEEN;
            emit      = 1'b0;
          end else begin
            res_bv   = 1'b1;
            res_byte = in_byte_r;
          end
        end
        PH_QSEEN: begin
          // doubled quote gives one quote; anything else closes the quoted part
          if (is_quote) begin
            phase_nxt = PH_QUOTED;
            res_bv    = 1'b1;
            res_byte  = in_byte_r;
          end else if (is_sep) begin
            phase_nxt = PH_START;
            res_fe    = 1'b1;
          end else begin
            phase_nxt = PH_AFTER;
            res_bv    = 1'b1;
            res_byte  = in_byte_r;
          end
        end
        default: begin
          // field start
          if (is_quote) begin
            phase_nxt = PH_QUOTED;
            emit      = 1'b0;
          end else if (is_sep) begin
            phase_nxt = PH_START;
            res_fe    = 1'b1;
          end else begin
            phase_nxt = PH_PLAIN;
            res_bv    = 1'b1;
            res_byte  = in_byte_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_idx_r <= 2'd0;
      parity_r   <= 1'b0;
      phase_r    <= PH_START;
      content_r  <= 1'b0;
    end else if (advance) begin
      line_idx_r <= line_idx_nxt;
      parity_r   <= parity_nxt;
      phase_r    <= phase_nxt;
      content_r  <= content_nxt;
    end
  end

  // result register
  logic                           out_v_nxt;
  logic                           bv_r;
  logic [csv_tok_pkg::ByteW-1:0]  byte_r;
  logic                           fe_r;
  logic                           re_r;
  logic [csv_tok_pkg::ClassW-1:0] class_r;

  always_comb begin
    if (advance) begin
      out_v_nxt = emit;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      bv_r    <= res_bv;
      byte_r  <= res_byte;
      fe_r    <= res_fe;
      re_r    <= res_re;
      class_r <= res_class;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.byte_valid = bv_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.field_end  = fe_r;
  assign out_ch.record_end = re_r;
  assign out_ch.row_class  = class_r;

  // line count only steps up by one
  a_line_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (line_idx_r != $past(line_idx_r)) |-> (line_idx_r == $past(line_idx_r) + 2'd1))
    else $error("line count moved other than by one");

  // a closed record leaves the line state cleared
  a_record_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit && res_re) |=> (phase_r == PH_START && !content_r))
    else $error("line state not cleared after record end");

  // an empty line is always at field start
  a_empty_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    !content_r |-> (phase_r == PH_START))
    else $error("field phase moved without line content");

  // input only stalls behind a held byte
  a_stall_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_v_r && out_v_r))
    else $error("input stalled with room downstream");

endmodule
